// ----- rtl/aesbcm_pkg.sv -----
// ----------------------------------------------------------------------------
// aesbcm_pkg
// Shared constants, codes, substitution tables and round functions of the
// AES block cipher modes unit.
// ----------------------------------------------------------------------------
package aesbcm_pkg;

   // Datapath geometry
   localparam int BlockWidth   = 128;
   localparam int RkWords      = 60;
   localparam int RowWords     = 4;
   localparam int RkRows       = RkWords / RowWords;
   localparam int RowAddrWidth = $clog2(RkRows);
   localparam int WordIdxWidth = $clog2(RkWords);

   // Mode codes
   localparam logic [2:0] ModeEcbEnc = 3'd0;
   localparam logic [2:0] ModeEcbDec = 3'd1;
   localparam logic [2:0] ModeCbcEnc = 3'd2;
   localparam logic [2:0] ModeCbcDec = 3'd3;
   localparam logic [2:0] ModeOfb    = 3'd4;
   localparam logic [2:0] ModeCtr    = 3'd5;

   // Key size codes
   localparam logic [1:0] KeySize128 = 2'd0;
   localparam logic [1:0] KeySize192 = 2'd1;
   localparam logic [1:0] KeySize256 = 2'd2;

   // Register indexes of the configuration port
   localparam logic [2:0] CsrKeySize = 3'd0;
   localparam logic [2:0] CsrMode    = 3'd1;
   localparam logic [2:0] CsrKey0    = 3'd2;
   localparam logic [2:0] CsrKey1    = 3'd3;
   localparam logic [2:0] CsrKey2    = 3'd4;
   localparam logic [2:0] CsrKey3    = 3'd5;
   localparam logic [2:0] CsrIvHi    = 3'd6;
   localparam logic [2:0] CsrIvLo    = 3'd7;

   // Control of one round step
   typedef struct packed {
      logic decrypt;
      logic first;
      logic last;
   } round_ctl_type;

   localparam logic [7:0] Sbox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] InvSbox [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // Multiply by x in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // S-box applied to each byte of a word
   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      sbox_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
   endfunction

   // Byte b of a block sits at the bottom for b = 0
   function automatic logic [127:0] sbox_state(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int b = 0; b < 16; b++) o[b*8 +: 8] = Sbox[s[b*8 +: 8]];
      sbox_state = o;
   endfunction

   function automatic logic [127:0] inv_sbox_state(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int b = 0; b < 16; b++) o[b*8 +: 8] = InvSbox[s[b*8 +: 8]];
      inv_sbox_state = o;
   endfunction

   function automatic logic [127:0] rotate_rows(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[(15 - (r + 4*c))*8 +: 8] = s[(15 - (r + 4*((c + r) % 4)))*8 +: 8];
      rotate_rows = o;
   endfunction

   function automatic logic [127:0] inv_rotate_rows(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[(15 - (r + 4*((c + r) % 4)))*8 +: 8] = s[(15 - (r + 4*c))*8 +: 8];
      inv_rotate_rows = o;
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] w);
      logic [7:0] a0, a1, a2, a3;
      a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
      mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // Products by 9, 11, 13 and 14 packed as one word
   function automatic logic [31:0] inv_terms(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
      inv_terms = {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [31:0] t0, t1, t2, t3;
      t0 = inv_terms(w[31:24]); t1 = inv_terms(w[23:16]);
      t2 = inv_terms(w[15:8]);  t3 = inv_terms(w[7:0]);
      // fields: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14
      inv_mix_col = {t0[7:0] ^ t1[23:16] ^ t2[15:8] ^ t3[31:24],
                     t0[31:24] ^ t1[7:0] ^ t2[23:16] ^ t3[15:8],
                     t0[15:8] ^ t1[31:24] ^ t2[7:0] ^ t3[23:16],
                     t0[23:16] ^ t1[15:8] ^ t2[31:24] ^ t3[7:0]};
   endfunction

   function automatic logic [127:0] mix_all_cols(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) o[c*32 +: 32] = mix_col(s[c*32 +: 32]);
      mix_all_cols = o;
   endfunction

   function automatic logic [127:0] inv_mix_all_cols(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) o[c*32 +: 32] = inv_mix_col(s[c*32 +: 32]);
      inv_mix_all_cols = o;
   endfunction

endpackage

// ----- rtl/aesbcm_ram.sv -----
// ----------------------------------------------------------------------------
// aesbcm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module aesbcm_ram #(
   parameter int Width = 128,
   parameter int Depth = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write, and read with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/aesbcm_round.sv -----
// ----------------------------------------------------------------------------
// aesbcm_round
// One AES round step, forward or inverse, with the round-key addition.
// ----------------------------------------------------------------------------
module aesbcm_round (
   input  aesbcm_pkg::round_ctl_type ctl,
   input  logic [127:0]              state_i,
   input  logic [127:0]              round_key,
   output logic [127:0]              state_o
);

   logic [127:0] fwd, inv;

   // Forward: sub, shift, mix except last, add key
   always_comb begin
      fwd = aesbcm_pkg::rotate_rows(aesbcm_pkg::sbox_state(state_i));
      if (!ctl.last) begin
         fwd = aesbcm_pkg::mix_all_cols(fwd);
      end
      fwd = fwd ^ round_key;
   end

   // Inverse: shift, sub, add key, mix except last
   always_comb begin
      inv = aesbcm_pkg::inv_sbox_state(aesbcm_pkg::inv_rotate_rows(state_i)) ^ round_key;
      if (!ctl.last) begin
         inv = aesbcm_pkg::inv_mix_all_cols(inv);
      end
   end

   // Initial step is the key addition alone
   always_comb begin
      if (ctl.first) begin
         state_o = state_i ^ round_key;
      end else if (ctl.decrypt) begin
         state_o = inv;
      end else begin
         state_o = fwd;
      end
   end

endmodule

// ----- rtl/aes_block_cipher_modes_unit.sv -----
// ----------------------------------------------------------------------------
// aes_block_cipher_modes_unit
// AES-128/192/256 in ECB, CBC, OFB and CTR modes with a round-key RAM.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  block_hi, block_lo, first_block
//   rsp      out        rsp_valid/rsp_stall  result_hi, result_lo
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A block passes from transfer through StLoad, then one StCipher step for the
// initial key addition and one per round, one round a cycle through the round
// unit, each round key read from the RAM a step ahead, then StDone, which
// registers the result; the next transfer can be taken in the same cycle the
// result shows. Modes 6 and 7 skip the rounds. A message start, or the first
// block after reset, first runs the key expansion, one word a cycle over all
// 60 words of the store. Reset is synchronous and clears the control state and
// the configuration registers; the payload registers are not reset. A result
// waiting under rsp_stall holds the unit in its final step.
module aes_block_cipher_modes_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   input  logic        req_first_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int AW = aesbcm_pkg::RowAddrWidth;
   localparam int IW = aesbcm_pkg::WordIdxWidth;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StExpand = 3'd1;
   localparam logic [2:0] StLoad   = 3'd2;
   localparam logic [2:0] StCipher = 3'd3;
   localparam logic [2:0] StDone   = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   key_size_ff;
   logic [2:0]   mode_ff;
   logic [255:0] key_ff;
   logic [127:0] iv_ff;
   logic [127:0] chain_ff, chain_in;
   logic         keys_ready_ff, keys_ready_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] cs_ff, cs_in;
   logic [3:0]   step_ff, step_in;
   logic [IW-1:0] widx_ff, widx_in;
   logic [2:0]   kmod_ff, kmod_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic [31:0]  rowbuf_ff [3];
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_ff, rsp_in;

   logic         req_xfer, rsp_free, decrypt, bypass, expand_now;
   logic [3:0]   nr;
   logic [3:0]   nk;
   logic [2:0]   nk_m1;
   logic [IW-1:0] total;
   logic [31:0]  key_word, prev, rot_t, exp_word, wr_word;
   logic         ram_we;
   logic [AW-1:0] rd_addr;
   logic [127:0] round_key, round_in, round_out, result;
   aesbcm_pkg::round_ctl_type round_ctl;

   // Key geometry; a size code of 3 counts as 256 bits
   always_comb begin
      case (key_size_ff)
         aesbcm_pkg::KeySize128: begin nr = 4'd10; nk = 4'd4; total = IW'(44); end
         aesbcm_pkg::KeySize192: begin nr = 4'd12; nk = 4'd6; total = IW'(52); end
         default:                begin nr = 4'd14; nk = 4'd8; total = IW'(60); end
      endcase
      nk_m1 = 3'(nk - 4'd1);
   end

   assign decrypt = (mode_ff == aesbcm_pkg::ModeEcbDec) || (mode_ff == aesbcm_pkg::ModeCbcDec);
   assign bypass  = mode_ff[2] & mode_ff[1];
   assign req_stall = (state_ff != StIdle);
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;
   assign expand_now = req_first_block | ~keys_ready_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         mode_ff     <= '0;
         key_ff      <= '0;
         iv_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            aesbcm_pkg::CsrKeySize: key_size_ff <= csr_data[1:0];
            aesbcm_pkg::CsrMode:    mode_ff <= csr_data[2:0];
            aesbcm_pkg::CsrKey0:    key_ff[255:192] <= csr_data;
            aesbcm_pkg::CsrKey1:    key_ff[191:128] <= csr_data;
            aesbcm_pkg::CsrKey2:    key_ff[127:64] <= csr_data;
            aesbcm_pkg::CsrKey3:    key_ff[63:0] <= csr_data;
            aesbcm_pkg::CsrIvHi:    iv_ff[127:64] <= csr_data;
            aesbcm_pkg::CsrIvLo:    iv_ff[63:0] <= csr_data;
            default:                ;
         endcase
      end
   end

   // Key expansion word; words beyond the schedule are stored as zero
   always_comb begin
      key_word = key_ff[{3'd7 - widx_ff[2:0], 5'd0} +: 32];
      prev     = win_ff[0];
      rot_t    = prev;
      if (kmod_ff == 3'd0) begin
         rot_t = aesbcm_pkg::sbox_word({prev[23:0], prev[31:24]}) ^ {rcon_ff, 24'd0};
      end else if (nk == 4'd8 && kmod_ff == 3'd4) begin
         rot_t = aesbcm_pkg::sbox_word(prev);
      end
      exp_word = (widx_ff < IW'(nk)) ? key_word : (rot_t ^ win_ff[nk_m1]);
      wr_word  = (widx_ff < total) ? exp_word : 32'd0;
      ram_we   = (state_ff == StExpand) && (widx_ff[1:0] == 2'd3);
   end

   // Read address one step ahead of the round that uses it
   always_comb begin
      if (state_ff == StLoad) begin
         rd_addr = decrypt ? AW'(nr) : AW'(0);
      end else begin
         rd_addr = decrypt ? AW'(nr - step_ff - 4'd1) : AW'(step_ff + 4'd1);
      end
   end

   aesbcm_ram #(
      .Width (aesbcm_pkg::BlockWidth),
      .Depth (aesbcm_pkg::RkRows)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (widx_ff[IW-1:2]),
      .wr_data ({rowbuf_ff[0], rowbuf_ff[1], rowbuf_ff[2], wr_word}),
      .rd_addr (rd_addr),
      .rd_data (round_key)
   );

   // Cipher input per mode on the first step
   always_comb begin
      case (mode_ff)
         aesbcm_pkg::ModeCbcEnc: round_in = blk_ff ^ chain_ff;
         aesbcm_pkg::ModeOfb,
         aesbcm_pkg::ModeCtr:    round_in = chain_ff;
         default:                round_in = blk_ff;
      endcase
      round_ctl.decrypt = decrypt;
      round_ctl.first   = (step_ff == 4'd0);
      round_ctl.last    = (step_ff == nr);
      if (step_ff != 4'd0) begin
         round_in = cs_ff;
      end
   end

   aesbcm_round u_round (
      .ctl       (round_ctl),
      .state_i   (round_in),
      .round_key (round_key),
      .state_o   (round_out)
   );

   // Result and chaining update per mode
   always_comb begin
      result   = blk_ff;
      chain_in = chain_ff;
      case (mode_ff)
         aesbcm_pkg::ModeEcbEnc,
         aesbcm_pkg::ModeEcbDec: result = cs_ff;
         aesbcm_pkg::ModeCbcEnc: begin result = cs_ff; chain_in = cs_ff; end
         aesbcm_pkg::ModeCbcDec: begin result = cs_ff ^ chain_ff; chain_in = blk_ff; end
         aesbcm_pkg::ModeOfb:    begin result = blk_ff ^ cs_ff; chain_in = cs_ff; end
         aesbcm_pkg::ModeCtr:    begin result = blk_ff ^ cs_ff; chain_in = chain_ff + 128'd1; end
         default:                ;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      blk_in        = blk_ff;
      cs_in         = cs_ff;
      step_in       = step_ff;
      widx_in       = widx_ff;
      kmod_in       = kmod_ff;
      rcon_in       = rcon_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               blk_in = {req_block_hi, req_block_lo};
               if (expand_now) begin
                  state_in      = StExpand;
                  keys_ready_in = 1'b1;
                  widx_in       = '0;
                  kmod_in       = '0;
                  rcon_in       = 8'h01;
               end else begin
                  state_in = bypass ? StDone : StLoad;
               end
            end
         end
         StExpand: begin
            widx_in = widx_ff + IW'(1);
            kmod_in = (kmod_ff == nk_m1) ? 3'd0 : kmod_ff + 3'd1;
            if (widx_ff >= IW'(nk) && kmod_ff == 3'd0) begin
               rcon_in = aesbcm_pkg::xtime(rcon_ff);
            end
            if (widx_ff == IW'(aesbcm_pkg::RkWords - 1)) begin
               state_in = bypass ? StDone : StLoad;
            end
         end
         StLoad: begin
            step_in  = 4'd0;
            state_in = StCipher;
         end
         StCipher: begin
            cs_in   = round_out;
            step_in = step_ff + 4'd1;
            if (step_ff == nr) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (rsp_free) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         chain_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (state_ff == StIdle && req_xfer && expand_now) begin
            chain_ff <= iv_ff;
         end else if (state_ff == StDone && rsp_free) begin
            chain_ff <= chain_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      cs_ff   <= cs_in;
      step_ff <= step_in;
      widx_ff <= widx_in;
      kmod_ff <= kmod_in;
      rcon_ff <= rcon_in;
      rsp_ff  <= rsp_in;
      if (state_ff == StExpand) begin
         win_ff[0] <= exp_word;
         for (int k = 1; k < 8; k++) win_ff[k] <= win_ff[k-1];
         if (widx_ff[1:0] != 2'd3) begin
            rowbuf_ff[widx_ff[1:0]] <= wr_word;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_hi = rsp_ff[127:64];
   assign rsp_result_lo = rsp_ff[63:0];

endmodule

// ----- rtl/aesbcm_checker.sv -----
// ----------------------------------------------------------------------------
// aesbcm_checker
// Port-level assertions on the AES block cipher modes unit.
// ----------------------------------------------------------------------------
module aesbcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_hi,
   input logic [63:0] rsp_result_lo,
   input logic        csr_ready
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_hi) && $stable(rsp_result_lo))
      else $error("stalled result changed");

   // Block further transfers while a block is at work
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // No result straight after a transfer in
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result too early");

   // Drop results on reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Configuration is taken whenever the unit is idle
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> csr_ready)
      else $error("configuration refused while idle");

endmodule

bind aes_block_cipher_modes_unit aesbcm_checker u_aesbcm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_result_hi (rsp_result_hi),
   .rsp_result_lo (rsp_result_lo),
   .csr_ready     (csr_ready)
);
